FILE: rtl/core/tlbr_pkg.sv
`timescale 1ns / 1ps

package tlbr_pkg;

    localparam int ADDR_W  = 32;
    localparam int FRAME_W = 8;
    localparam int PAGE_W  = 25;
    localparam int SLOT_W  = 2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_PAGE_RD,
        ST_UPDATE,
        ST_FILL,
        ST_DONE
    } t_state;

endpackage

FILE: rtl/core/tlb_refill_lru_replacement.sv
`timescale 1ns / 1ps

// TLB refill with least-recently-used replacement.
//
// Command channel: an item (fault address and frame number) is taken at a
// rising edge where start is high and busy is low. busy stays high until the
// result has been shown. The result (slot, replaced flag, evicted page) is
// marked by o_done, which is high for exactly one cycle; the receiver
// cannot stall, so nothing waits on it.
//
// Items are not overlapped: the next item can be taken in the cycle after
// o_done. The time per item is set by the single read port of the age
// store: one walk over all entries finds the free entry or the oldest one,
// a second walk ages every other entry and clears the chosen one, one entry
// per cycle each.
//
// Reset clears the valid bits and the sequencer. Ages, pages and frames of
// entries that were never filled are not cleared; their values never decide
// a choice or an output, as only valid entries are compared or evicted.
module tlb_refill_lru_replacement #(
    parameter int TLB_ENTRIES = 4,
    parameter int PAGE_BYTES  = 128,
    parameter int AGE_BITS    = 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [tlbr_pkg::ADDR_W-1:0]   i_fault_address,
    input  logic [tlbr_pkg::FRAME_W-1:0]  i_frame_number,
    output logic                          o_done,
    output logic [tlbr_pkg::SLOT_W-1:0]   o_slot,
    output logic                          o_replaced_valid,
    output logic [tlbr_pkg::PAGE_W-1:0]   o_evicted_page
);

    import tlbr_pkg::*;

    localparam int IDX_W = $clog2(TLB_ENTRIES);
    localparam int OFF_W = $clog2(PAGE_BYTES);
    localparam logic [IDX_W-1:0]    LAST    = IDX_W'(TLB_ENTRIES - 1);
    localparam logic [AGE_BITS-1:0] AGE_MAX = {AGE_BITS{1'b1}};

    t_state r_state, n_state;

    logic [TLB_ENTRIES-1:0] r_valid;

    logic [AGE_BITS-1:0] mem_age  [TLB_ENTRIES];
    logic [PAGE_W-1:0]   mem_page [TLB_ENTRIES];
    logic [FRAME_W-1:0]  mem_frame[TLB_ENTRIES];

    logic [PAGE_W-1:0]   r_page_new;
    logic [FRAME_W-1:0]  r_frame_new;
    logic [PAGE_W-1:0]   r_page_q;
    logic [AGE_BITS-1:0] r_age_q;

    logic [IDX_W-1:0]    r_idx;
    logic                r_issue;
    logic [IDX_W-1:0]    r_chk_idx;
    logic                r_chk_vld;

    logic [IDX_W-1:0]    r_best;
    logic [AGE_BITS-1:0] r_best_age;
    logic                r_found_free;

    logic                accept;
    logic                last_chk;
    logic                walk;
    logic                age_we;
    logic [AGE_BITS-1:0] age_wdata;
    logic                page_rd;
    logic                fill;

    assign accept   = start && !busy;
    assign last_chk = r_chk_vld && (r_chk_idx == LAST);

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:    if (start) n_state = ST_SCAN;
            ST_SCAN:    if (last_chk) n_state = ST_PAGE_RD;
            ST_PAGE_RD: n_state = ST_UPDATE;
            ST_UPDATE:  if (last_chk) n_state = ST_FILL;
            ST_FILL:    n_state = ST_DONE;
            ST_DONE:    n_state = ST_IDLE;
            default:    n_state = ST_IDLE;
        endcase
    end

    // Control outputs.
    always_comb begin
        busy    = 1'b1;
        walk    = 1'b0;
        age_we  = 1'b0;
        page_rd = 1'b0;
        fill    = 1'b0;
        o_done  = 1'b0;
        unique case (r_state)
            ST_IDLE:    busy = 1'b0;
            ST_SCAN:    walk = 1'b1;
            ST_PAGE_RD: page_rd = 1'b1;
            ST_UPDATE: begin
                walk   = 1'b1;
                age_we = r_chk_vld;
            end
            ST_FILL:    fill = 1'b1;
            ST_DONE:    o_done = 1'b1;
            default:    busy = 1'b1;
        endcase
    end

    // The chosen entry restarts at zero; every other one ages, saturating.
    always_comb begin
        if (r_chk_idx == r_best) begin
            age_wdata = '0;
        end else if (r_age_q == AGE_MAX) begin
            age_wdata = r_age_q;
        end else begin
            age_wdata = r_age_q + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Walk counters: an issue stage addresses the age store, a check stage
    // sees the registered read data in the following cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx     <= '0;
            r_issue   <= 1'b0;
            r_chk_vld <= 1'b0;
            r_chk_idx <= '0;
        end else if (accept || page_rd) begin
            r_idx     <= '0;
            r_issue   <= 1'b1;
            r_chk_vld <= 1'b0;
        end else if (walk) begin
            r_chk_vld <= r_issue;
            r_chk_idx <= r_idx;
            if (r_issue) begin
                r_idx <= r_idx + 1'b1;
                if (r_idx == LAST) begin
                    r_issue <= 1'b0;
                end
            end
        end
    end

    // Selection: the first invalid entry wins; while all entries so far are
    // valid, keep the oldest, the lower index on ties.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found_free <= 1'b0;
        end else if (accept) begin
            r_found_free <= 1'b0;
        end else if (r_state == ST_SCAN && r_chk_vld && !r_found_free) begin
            if (!r_valid[r_chk_idx]) begin
                r_found_free <= 1'b1;
                r_best       <= r_chk_idx;
            end else if (r_chk_idx == '0 || r_age_q > r_best_age) begin
                r_best       <= r_chk_idx;
                r_best_age   <= r_age_q;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_page_new  <= PAGE_W'(i_fault_address >> OFF_W);
            r_frame_new <= i_frame_number;
        end
    end

    always_ff @(posedge i_clk) begin
        if (walk && r_issue) begin
            r_age_q <= mem_age[r_idx];
        end
        if (age_we) begin
            mem_age[r_chk_idx] <= age_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (page_rd) begin
            r_page_q <= mem_page[r_best];
        end
        if (fill) begin
            mem_page[r_best]  <= r_page_new;
            mem_frame[r_best] <= r_frame_new;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (fill) begin
            r_valid[r_best] <= 1'b1;
        end
    end

    assign o_slot           = SLOT_W'(r_best);
    assign o_replaced_valid = !r_found_free;
    assign o_evicted_page   = r_found_free ? '0 : r_page_q;

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> busy)
        else $error("busy not raised after an accepted item");

    a_idle_after_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !busy)
        else $error("block still busy after the result");

    a_slot_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> r_valid[r_best])
        else $error("filled entry not marked valid");

    a_evict_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_replaced_valid) |-> (&r_valid))
        else $error("eviction while a free entry existed");

endmodule

FILE: sim/tb_tlb_refill_lru_replacement.sv
`timescale 1ns / 1ps

module tb_tlb_refill_lru_replacement;
    import tlbr_pkg::*;

    localparam int ENTRIES    = 4;
    localparam int PAGE_BYTES = 128;
    localparam int AGE_BITS   = 8;
    localparam logic [AGE_BITS-1:0] AGE_TOP = '1;
    localparam int RANDOM_ITEMS = 1400;
    localparam int PHASES       = 4;

    typedef struct packed {
        logic [SLOT_W-1:0] slot;
        logic              replaced;
        logic [PAGE_W-1:0] victim_page;
    } t_refill;

    typedef struct packed {
        logic [ADDR_W-1:0]  addr;
        logic [FRAME_W-1:0] frame;
        logic               typed;
        t_refill            want;
    } t_fault_row;

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                start;
    logic                busy;
    logic [ADDR_W-1:0]   i_fault_address;
    logic [FRAME_W-1:0]  i_frame_number;
    logic                o_done;
    logic [SLOT_W-1:0]   o_slot;
    logic                o_replaced_valid;
    logic [PAGE_W-1:0]   o_evicted_page;

    // Shadow copy of the TLB used to predict each refill.
    logic                tlb_valid [ENTRIES];
    logic [PAGE_W-1:0]   tlb_page  [ENTRIES];
    logic [AGE_BITS-1:0] tlb_age   [ENTRIES];

    t_refill    expected_refills [$];
    t_fault_row directed_faults  [$];
    t_refill    oldest_refill;
    int         mismatches = 0;

    tlb_refill_lru_replacement #(
        .TLB_ENTRIES(ENTRIES),
        .PAGE_BYTES (PAGE_BYTES),
        .AGE_BITS   (AGE_BITS)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_fault_address (i_fault_address),
        .i_frame_number  (i_frame_number),
        .o_done          (o_done),
        .o_slot          (o_slot),
        .o_replaced_valid(o_replaced_valid),
        .o_evicted_page  (o_evicted_page)
    );

    always #5 i_clk = ~i_clk;

    function automatic t_refill predict_refill(input logic [ADDR_W-1:0] addr);
        int      pick;
        bit      found;
        t_refill r;
        logic [ADDR_W-1:0] page_full;
        pick  = 0;
        found = 0;
        for (int k = 0; k < ENTRIES; k++) begin
            if (!found && !tlb_valid[k]) begin
                pick  = k;
                found = 1;
            end
        end
        if (!found) begin
            // Strict compare keeps the lowest index on equal ages.
            for (int k = 1; k < ENTRIES; k++) begin
                if (tlb_age[k] > tlb_age[pick]) pick = k;
            end
        end
        r.slot        = SLOT_W'(pick);
        r.replaced    = !found;
        r.victim_page = found ? '0 : tlb_page[pick];
        // Unchosen entries age whether valid or not.
        for (int k = 0; k < ENTRIES; k++) begin
            if (k != pick && tlb_age[k] != AGE_TOP) tlb_age[k] = tlb_age[k] + 1'b1;
        end
        page_full       = addr / PAGE_BYTES;
        tlb_age[pick]   = '0;
        tlb_valid[pick] = 1'b1;
        tlb_page[pick]  = page_full[PAGE_W-1:0];
        return r;
    endfunction

    task automatic add_row(input logic [ADDR_W-1:0] addr, input logic [FRAME_W-1:0] frame,
                           input logic typed, input logic [SLOT_W-1:0] slot,
                           input logic replaced, input logic [PAGE_W-1:0] victim);
        t_fault_row r;
        r.addr             = addr;
        r.frame            = frame;
        r.typed            = typed;
        r.want.slot        = slot;
        r.want.replaced    = replaced;
        r.want.victim_page = victim;
        directed_faults.push_back(r);
    endtask

    // Called at a falling edge; returns at the falling edge after the item was
    // taken, with start still high so the next item can follow back to back.
    task automatic send_fault(input t_fault_row row, input int idle_pct);
        bit      taken;
        t_refill guess;
        taken = 0;
        while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(negedge i_clk);
        end
        start           <= 1'b1;
        i_fault_address <= row.addr;
        i_frame_number  <= row.frame;
        while (!taken) begin
            @(posedge i_clk);
            taken = !busy;
        end
        guess = predict_refill(row.addr);
        expected_refills.push_back(row.typed ? row.want : guess);
        @(negedge i_clk);
    endtask

    task automatic drain_refills();
        start <= 1'b0;
        @(negedge i_clk);
        while (expected_refills.size() != 0) @(negedge i_clk);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            if (expected_refills.size() == 0) begin
                $display("%0t: unexpected result slot=%0d replaced=%0b page=%h",
                         $time, o_slot, o_replaced_valid, o_evicted_page);
                mismatches++;
            end else begin
                oldest_refill = expected_refills.pop_front();
                if (o_slot !== oldest_refill.slot) begin
                    $display("%0t: slot expected %0d actual %0d",
                             $time, oldest_refill.slot, o_slot);
                    mismatches++;
                end
                if (o_replaced_valid !== oldest_refill.replaced) begin
                    $display("%0t: replaced_valid expected %0b actual %0b",
                             $time, oldest_refill.replaced, o_replaced_valid);
                    mismatches++;
                end
                if (o_evicted_page !== oldest_refill.victim_page) begin
                    $display("%0t: evicted_page expected %h actual %h",
                             $time, oldest_refill.victim_page, o_evicted_page);
                    mismatches++;
                end
            end
        end
    end

    initial begin
        #(5_000_000);
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        t_fault_row        row;
        int                idle;
        int                kind;
        logic [31:0]       r32;
        logic [ADDR_W-1:0] recent_addr;

        i_rst_n         = 1'b0;
        start           = 1'b0;
        i_fault_address = '0;
        i_frame_number  = '0;
        recent_addr     = '0;
        for (int k = 0; k < ENTRIES; k++) begin
            tlb_valid[k] = 1'b0;
            tlb_page[k]  = '0;
            tlb_age[k]   = '0;
        end

        // Empty TLB fills slots in order, then the oldest entry goes each time.
        add_row(32'h0000_0000, 8'h00, 1'b1, 2'd0, 1'b0, 25'h0000000);
        add_row(32'hFFFF_FFFF, 8'hFF, 1'b1, 2'd1, 1'b0, 25'h0000000);
        add_row(32'h0000_007F, 8'h5A, 1'b1, 2'd2, 1'b0, 25'h0000000);
        add_row(32'h0000_0080, 8'hA5, 1'b1, 2'd3, 1'b0, 25'h0000000);
        add_row(32'h8000_0000, 8'h01, 1'b1, 2'd0, 1'b1, 25'h0000000);
        add_row(32'h1234_5678, 8'h80, 1'b1, 2'd1, 1'b1, 25'h1FFFFFF);
        add_row(32'h0000_0100, 8'h7F, 1'b1, 2'd2, 1'b1, 25'h0000000);
        add_row(32'hFFFF_FF80, 8'h3C, 1'b1, 2'd3, 1'b1, 25'h0000001);
        add_row(32'h7FFF_FFFF, 8'hC3, 1'b0, '0, 1'b0, '0);
        add_row(32'h5555_5555, 8'h55, 1'b0, '0, 1'b0, '0);
        add_row(32'hAAAA_AAAA, 8'hAA, 1'b0, '0, 1'b0, '0);
        add_row(32'hFFFF_FFFF, 8'h0F, 1'b0, '0, 1'b0, '0);
        add_row(32'hFFFF_FFFF, 8'hF0, 1'b0, '0, 1'b0, '0);
        add_row(32'h0000_0000, 8'h00, 1'b0, '0, 1'b0, '0);

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (directed_faults[i]) send_fault(directed_faults[i], 0);
        drain_refills();

        for (int phase = 0; phase < PHASES; phase++) begin
            // Phases 1 and 3 add idle gaps; phases 0 and 2 have none. The receiver cannot stall.
            idle = (phase == 1) ? 71 : (phase == 3) ? 31 : 0;
            for (int n = 0; n < RANDOM_ITEMS / PHASES; n++) begin
                kind = $urandom_range(9);
                r32  = $urandom;
                case (kind)
                    4, 5:    row.addr = $urandom_range(0, 1023);
                    6:       row.addr = 32'hFFFF_FC00 | $urandom_range(0, 1023);
                    7:       row.addr = {r32[31:7], ($urandom_range(1) ? 7'h7F : 7'h00)};
                    8:       row.addr = recent_addr ^ $urandom_range(0, PAGE_BYTES - 1);
                    9:       row.addr = ($urandom_range(1) ? 32'hAAAA_AAAA : 32'h5555_5555)
                                        ^ (32'h1 << $urandom_range(31));
                    default: row.addr = r32;
                endcase
                row.frame   = $urandom_range(255);
                row.typed   = 1'b0;
                row.want    = '0;
                recent_addr = row.addr;
                send_fault(row, idle);
            end
            drain_refills();
        end

        repeat (40) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
